// ----- hw/rtl/uidac_pkg.sv -----
// package: item types, phase and action codes, select code lookup for the uid detection sequencer
package uidac_pkg;

    localparam int unsigned MAX_LEVELS_DEF = 3;
    localparam int unsigned UID_WORDS      = 3;

    localparam logic [7:0] NVB_ANTICOL  = 8'h20;
    localparam logic [7:0] NVB_SELECT   = 8'h70;
    localparam logic [7:0] ATQA_INVALID = 8'hff;
    localparam int unsigned ATQA_RFU_BIT = 5;
    localparam int unsigned SAK_CASC_BIT = 2;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ATQA    = 4'b0010,
        PH_ANTICOL = 4'b0100,
        PH_SAK     = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ACT_REQA     = 3'd0,
        ACT_ANTICOL  = 3'd1,
        ACT_SELECT   = 3'd2,
        ACT_DETECTED = 3'd3,
        ACT_FAILED   = 3'd4,
        ACT_IGNORED  = 3'd5
    } action_t;

    typedef enum logic {
        OP_START    = 1'b0,
        OP_RESPONSE = 1'b1
    } op_t;

    typedef struct packed {
        logic       op;
        logic       frame_ok;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
    } in_item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  sel_code;
        logic [7:0]  nvb;
        logic [31:0] select_uid_bytes;
        logic [7:0]  check_byte;
        logic [63:0] uid_low;
        logic [31:0] uid_high;
        logic [1:0]  levels_done;
    } out_item_t;

    // select command code for a cascade level
    function automatic logic [7:0] sel_code_of(input logic [1:0] level);
        logic [7:0] code;
        case (level)
            2'd0:    code = 8'h93;
            2'd1:    code = 8'h95;
            default: code = 8'h97;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/iso14443a_uid_anticollision.sv -----
// top level: reader-side card detection sequencer with cascade anticollision
// each accepted item's result is registered in the result register (m_item_reg)
// throughput: one item per cycle while results are taken; the only loop is the phase/uid state update
// a result that is held off by m_ready stalls the input until it is taken
// reset (aresetn low, synchronous): phase idle, cascade counts and uid store zero
module iso14443a_uid_anticollision #(
    parameter int unsigned MAX_LEVELS = uidac_pkg::MAX_LEVELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uidac_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output uidac_pkg::out_item_t m_item
);
    import uidac_pkg::*;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [1:0]  now_reg, now_next;       // cascade level being worked on
    logic [1:0]  last_reg, last_next;     // last cascade level announced by atqa
    logic [1:0]  levels_reg, levels_next; // levels stored so far
    logic [31:0] uid_reg [UID_WORDS];
    logic [31:0] uid_next [UID_WORDS];

    // result register
    logic        m_valid_reg;
    out_item_t   m_item_reg;
    out_item_t   res;

    logic        accept;
    logic [2:0]  atqa_count;
    logic        atqa_bad;
    logic [7:0]  xor4;
    logic [7:0]  xor5;
    logic [31:0] word;

    // accept whenever the result register is empty or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // atqa checks: bad frame, all-ones, rfu bit, or too many cascade levels
    assign atqa_count = {1'b0, s_item.byte0[7:6]} + 3'd1;
    assign atqa_bad   = !s_item.frame_ok || (s_item.byte0 == ATQA_INVALID)
                        || s_item.byte0[ATQA_RFU_BIT]
                        || (atqa_count > 3'(MAX_LEVELS));

    // anticollision reply: four uid bytes plus bcc
    assign xor4 = s_item.byte0 ^ s_item.byte1 ^ s_item.byte2 ^ s_item.byte3;
    assign xor5 = xor4 ^ s_item.byte4;
    assign word = {s_item.byte3, s_item.byte2, s_item.byte1, s_item.byte0};

    always_comb begin
        phase_next  = phase_reg;
        now_next    = now_reg;
        last_next   = last_reg;
        levels_next = levels_reg;
        for (int i = 0; i < UID_WORDS; i++) begin
            uid_next[i] = uid_reg[i];
        end
        res        = '0;
        res.action = ACT_IGNORED;

        if (s_item.op == OP_START) begin
            // restart from any phase, wipe the uid store
            phase_next  = PH_ATQA;
            now_next    = '0;
            last_next   = '0;
            levels_next = '0;
            for (int i = 0; i < UID_WORDS; i++) begin
                uid_next[i] = '0;
            end
            res.action = ACT_REQA;
        end else begin
            unique case (phase_reg)
                PH_ATQA: begin
                    if (atqa_bad) begin
                        phase_next = PH_IDLE;
                        res.action = ACT_FAILED;
                    end else begin
                        now_next   = '0;
                        last_next  = s_item.byte0[7:6];
                        phase_next = PH_ANTICOL;
                        res.action = ACT_ANTICOL;
                    end
                end
                PH_ANTICOL: begin
                    if (!s_item.frame_ok || (xor5 != 8'd0) || (now_reg > 2'd2)) begin
                        phase_next = PH_IDLE;
                        res.action = ACT_FAILED;
                    end else begin
                        // cascade tag is stored like any other uid byte
                        uid_next[now_reg]    = word;
                        levels_next          = now_reg + 2'd1;
                        phase_next           = PH_SAK;
                        res.action           = ACT_SELECT;
                        res.select_uid_bytes = word;
                        res.check_byte       = xor4;
                    end
                end
                PH_SAK: begin
                    if (!s_item.frame_ok) begin
                        phase_next = PH_IDLE;
                        res.action = ACT_FAILED;
                    end else if (s_item.byte0[SAK_CASC_BIT] && (now_reg < last_reg)) begin
                        // uid not complete, go down one cascade level
                        now_next   = now_reg + 2'd1;
                        phase_next = PH_ANTICOL;
                        res.action = ACT_ANTICOL;
                    end else begin
                        phase_next = PH_IDLE;
                        res.action = ACT_DETECTED;
                    end
                end
                default: begin
                    res.action = ACT_IGNORED;
                end
            endcase
        end

        // command framing fields follow the new cascade level
        if (res.action == ACT_ANTICOL) begin
            res.sel_code = sel_code_of(now_next);
            res.nvb      = NVB_ANTICOL;
        end else if (res.action == ACT_SELECT) begin
            res.sel_code = sel_code_of(now_next);
            res.nvb      = NVB_SELECT;
        end

        // uid store is reported after this item's update
        res.uid_low     = {uid_next[1], uid_next[0]};
        res.uid_high    = uid_next[2];
        res.levels_done = levels_next;
    end

    // state update on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            now_reg    <= '0;
            last_reg   <= '0;
            levels_reg <= '0;
            for (int i = 0; i < UID_WORDS; i++) begin
                uid_reg[i] <= '0;
            end
        end else if (accept) begin
            phase_reg  <= phase_next;
            now_reg    <= now_next;
            last_reg   <= last_next;
            levels_reg <= levels_next;
            for (int i = 0; i < UID_WORDS; i++) begin
                uid_reg[i] <= uid_next[i];
            end
        end
    end

    // result register: valid is control, payload loads on accept only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= res;
        end
    end

`ifndef SYNTH
    // the working level never passes the last announced level
    assert property (@(posedge aclk) disable iff (!aresetn)
        now_reg <= last_reg)
        else $error("cascade level beyond announced count");

    // a response while idle is ignored
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_item.op == OP_RESPONSE) && (phase_reg == PH_IDLE)
        |=> m_valid && (m_item.action == ACT_IGNORED))
        else $error("response while idle not ignored");

    // a start gives reqa with an empty uid store
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_item.op == OP_START)
        |=> m_valid && (m_item.action == ACT_REQA) && (m_item.uid_low == 64'd0)
            && (m_item.uid_high == 32'd0) && (m_item.levels_done == 2'd0))
        else $error("start did not clear the uid store");

    // select result carries a consistent bcc
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.action == ACT_SELECT)
        |-> (m_item.check_byte == (m_item.select_uid_bytes[7:0]
            ^ m_item.select_uid_bytes[15:8] ^ m_item.select_uid_bytes[23:16]
            ^ m_item.select_uid_bytes[31:24])) && (m_item.nvb == NVB_SELECT))
        else $error("select bcc mismatch");
`endif

endmodule

// ----- tb/uidac_checker.sv -----
// checker: follows both channels, predicts each result of the uid detection sequencer and compares
`timescale 1ns / 100ps

module uidac_checker #(
    parameter int unsigned MAX_LEVELS = uidac_pkg::MAX_LEVELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  uidac_pkg::in_item_t  s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  uidac_pkg::out_item_t m_item,
    output int                   fail_count,
    output int                   pending
);
    import uidac_pkg::*;

    phase_t      ph = PH_IDLE;
    logic [1:0]  lvl_now;
    logic [1:0]  lvl_last;
    logic [1:0]  lvl_stored;
    logic [31:0] uid_word [UID_WORDS];
    out_item_t   reply_q [$];
    int          n_fail = 0;
    int          n_pending = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    function automatic logic [7:0] level_code(input logic [1:0] lvl);
        logic [7:0] code;
        case (lvl)
            2'd0:    code = 8'h93;
            2'd1:    code = 8'h95;
            default: code = 8'h97;
        endcase
        return code;
    endfunction

    function automatic void clear_detector();
        ph         = PH_IDLE;
        lvl_now    = 2'd0;
        lvl_last   = 2'd0;
        lvl_stored = 2'd0;
        for (int i = 0; i < UID_WORDS; i++) uid_word[i] = 32'd0;
    endfunction

    // advances the detector state by one item and returns the result it gives
    function automatic out_item_t next_reply(input in_item_t it);
        out_item_t   r;
        action_t     act;
        int unsigned cnt;
        logic [7:0]  x4;
        logic [31:0] w;
        r   = '0;
        x4  = it.byte0 ^ it.byte1 ^ it.byte2 ^ it.byte3;
        w   = {it.byte3, it.byte2, it.byte1, it.byte0};
        cnt = int'(it.byte0[7:6]) + 1;
        if (it.op == OP_START) begin
            clear_detector();
            ph  = PH_ATQA;
            act = ACT_REQA;
        end else begin
            case (ph)
                PH_ATQA: begin
                    if (!it.frame_ok || it.byte0 == ATQA_INVALID || it.byte0[ATQA_RFU_BIT]
                            || cnt > MAX_LEVELS) begin
                        ph  = PH_IDLE;
                        act = ACT_FAILED;
                    end else begin
                        lvl_now  = 2'd0;
                        lvl_last = 2'(cnt - 1);
                        ph       = PH_ANTICOL;
                        act      = ACT_ANTICOL;
                    end
                end
                PH_ANTICOL: begin
                    if (!it.frame_ok || (x4 ^ it.byte4) != 8'd0 || lvl_now > 2'd2) begin
                        ph  = PH_IDLE;
                        act = ACT_FAILED;
                    end else begin
                        uid_word[lvl_now]  = w;
                        lvl_stored         = lvl_now + 2'd1;
                        ph                 = PH_SAK;
                        act                = ACT_SELECT;
                        r.select_uid_bytes = w;
                        r.check_byte       = x4;
                    end
                end
                PH_SAK: begin
                    if (!it.frame_ok) begin
                        ph  = PH_IDLE;
                        act = ACT_FAILED;
                    end else if (it.byte0[SAK_CASC_BIT] && lvl_now < lvl_last) begin
                        lvl_now = lvl_now + 2'd1;
                        ph      = PH_ANTICOL;
                        act     = ACT_ANTICOL;
                    end else begin
                        ph  = PH_IDLE;
                        act = ACT_DETECTED;
                    end
                end
                default: act = ACT_IGNORED;
            endcase
        end
        if (act == ACT_ANTICOL) begin
            r.sel_code = level_code(lvl_now);
            r.nvb      = NVB_ANTICOL;
        end else if (act == ACT_SELECT) begin
            r.sel_code = level_code(lvl_now);
            r.nvb      = NVB_SELECT;
        end
        r.action      = act;
        r.uid_low     = {uid_word[1], uid_word[0]};
        r.uid_high    = uid_word[2];
        r.levels_done = lvl_stored;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic check_reply(input out_item_t got);
        out_item_t want;
        if (reply_q.size() == 0) begin
            $error("result item with no item waiting for it: %0h", got);
            n_fail++;
        end else begin
            want = reply_q.pop_front();
            check_field("action", want.action, got.action);
            check_field("sel_code", want.sel_code, got.sel_code);
            check_field("nvb", want.nvb, got.nvb);
            check_field("select_uid_bytes", want.select_uid_bytes, got.select_uid_bytes);
            check_field("check_byte", want.check_byte, got.check_byte);
            check_field("uid_low", want.uid_low, got.uid_low);
            check_field("uid_high", want.uid_high, got.uid_high);
            check_field("levels_done", want.levels_done, got.levels_done);
        end
    endtask

    // results come back in order, so the oldest waiting one is taken first
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_detector();
            reply_q.delete();
        end else begin
            if (m_valid && m_ready) check_reply(m_item);
            if (s_valid && s_ready) reply_q.push_back(next_reply(s_item));
        end
        n_pending = reply_q.size();
    end

endmodule

// ----- tb/iso14443a_uid_anticollision_tb.sv -----
// testbench top: drives detection sequences into the sequencer and reports the verdict
`timescale 1ns / 100ps

module iso14443a_uid_anticollision_tb;
    import uidac_pkg::*;

    localparam int RANDOM_ITEMS = 850;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int fail_count;
    int pending;

    // shared between the sender and the receiver
    bit calm;       // no idling on either side while set
    bit hold_req;   // asks the receiver for a long hold-off
    int n_sent;     // items that move the sequence along

    iso14443a_uid_anticollision i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    uidac_checker i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random backpressure, a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                // counted here, the sender keeps offering items meanwhile
                repeat (63) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    function automatic logic [7:0] rnd_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic in_item_t mk_item(input op_t op, input logic ok, input logic [7:0] b0,
                                         input logic [7:0] b1, input logic [7:0] b2,
                                         input logic [7:0] b3, input logic [7:0] b4);
        in_item_t it;
        it.op       = op;
        it.frame_ok = ok;
        it.byte0    = b0;
        it.byte1    = b1;
        it.byte2    = b2;
        it.byte3    = b3;
        it.byte4    = b4;
        return it;
    endfunction

    // offers one item at a falling edge and holds it until accepted
    task automatic put_item(input in_item_t it);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // start item: payload bytes and frame flag are don't-care, so randomize them
    task automatic put_start();
        put_item(mk_item(OP_START, 1'($urandom_range(0, 1)), rnd_byte(), rnd_byte(),
                         rnd_byte(), rnd_byte(), rnd_byte()));
        n_sent++;
    endtask

    task automatic put_resp(input logic ok, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4);
        put_item(mk_item(OP_RESPONSE, ok, b0, b1, b2, b3, b4));
        n_sent++;
    endtask

    // anticollision reply with a proper bcc, or a corrupted one
    task automatic put_uid(input logic ok, input logic [31:0] w, input bit corrupt);
        logic [7:0] bcc;
        bcc = w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
        if (corrupt) bcc = bcc ^ 8'($urandom_range(1, 255));
        put_resp(ok, w[7:0], w[15:8], w[23:16], w[31:24], bcc);
    endtask

    // sender goes quiet until every result has been taken
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] rnd_uid(input bit tag);
        logic [31:0] w;
        case ($urandom_range(0, 19))
            0:       w = 32'h0000_0000;
            1:       w = 32'hffff_ffff;
            default: w = $urandom;
        endcase
        if (tag) w[7:0] = 8'h88;   // cascade tag, stored like any uid byte
        return w;
    endfunction

    // one detection attempt: mostly well formed, with failures sprinkled in
    task automatic run_session();
        int         levels;
        int         r;
        logic [7:0] b0;
        if ($urandom_range(0, 99) < 8) begin
            // noise: anything at all, often a response while idle
            put_item(mk_item(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte()));
            return;
        end
        put_start();
        levels = $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 15) begin
            // broken atqa
            b0 = rnd_byte();
            case ($urandom_range(0, 3))
                0: put_resp(1'b0, {levels[1:0], 1'b0, b0[4:0]}, rnd_byte(), rnd_byte(),
                            rnd_byte(), rnd_byte());
                1: put_resp(1'b1, ATQA_INVALID, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
                2: put_resp(1'b1, {b0[7:6], 1'b1, b0[4:0]}, rnd_byte(), rnd_byte(),
                            rnd_byte(), rnd_byte());
                default: put_resp(1'b1, {2'b11, 1'b0, b0[4:0]}, rnd_byte(), rnd_byte(),
                                  rnd_byte(), rnd_byte());
            endcase
            return;
        end
        b0 = rnd_byte();
        put_resp(1'b1, {levels[1:0], 1'b0, b0[4:0]}, rnd_byte(), rnd_byte(), rnd_byte(),
                 rnd_byte());
        for (int lvl = 0; lvl <= levels; lvl++) begin
            if ($urandom_range(0, 99) < 3) begin
                put_start();   // restart in the middle of a sequence
                return;
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                put_uid(1'b0, rnd_uid(0), 0);
                return;
            end else if (r < 10) begin
                put_uid(1'b1, rnd_uid(0), 1);
                return;
            end
            put_uid(1'b1, rnd_uid(lvl < levels && $urandom_range(0, 99) < 30), 0);
            b0 = rnd_byte();
            if (lvl < levels) b0[SAK_CASC_BIT] = ($urandom_range(0, 99) < 90);
            if ($urandom_range(0, 99) < 6) begin
                put_resp(1'b0, b0, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
                return;
            end
            put_resp(1'b1, b0, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
            if (!b0[SAK_CASC_BIT]) return;   // uid complete early
        end
    endtask

    initial begin
        int  n_directed;
        bit  hold_done;
        bit  pause_done;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        n_sent    = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        // response while nothing is running is ignored
        put_resp(1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        // atqa arriving with a frame error
        put_start();
        put_resp(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // atqa first byte all ones
        put_start();
        put_resp(1'b1, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
        // atqa with the rfu bit set
        put_start();
        put_resp(1'b1, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00);
        // reserved cascade count
        put_start();
        put_resp(1'b1, 8'hc0, 8'hff, 8'hff, 8'hff, 8'hff);
        // single level, reply with a wrong bcc
        put_start();
        put_resp(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        put_uid(1'b1, 32'h1234_5678, 1);
        // double level, cascade bit still set on the last sak
        put_start();
        put_resp(1'b1, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00);
        put_uid(1'b1, 32'haabb_cc88, 0);
        put_resp(1'b1, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
        put_uid(1'b1, 32'hffff_ffff, 0);
        put_resp(1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        // triple level, select reply at the third level has a frame error
        put_start();
        put_resp(1'b1, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
        put_uid(1'b1, 32'h0000_0000, 0);
        put_resp(1'b1, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00);
        put_uid(1'b1, 32'h0302_0188, 0);
        put_resp(1'b1, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
        put_uid(1'b1, 32'hdead_beef, 0);
        put_resp(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        n_directed = n_sent;
        drain();

        // random part
        while (n_sent < n_directed + RANDOM_ITEMS) begin
            if (!hold_done && n_sent > n_directed + 150) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            calm = (n_sent > n_directed + 350) && (n_sent < n_directed + 500);
            if (!pause_done && n_sent > n_directed + 600) begin
                pause_done = 1'b1;
                drain();
            end
            run_session();
        end
        calm = 1'b0;

        // wind down: let every result come back, then a few idle cycles
        drain();
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/uidac_pkg.sv
hw/rtl/iso14443a_uid_anticollision.sv
tb/uidac_checker.sv
tb/iso14443a_uid_anticollision_tb.sv
